@@ src/mfm_pkg.sv @@
// ----------------------------------------------------------------------------
// mfm_pkg
// shared types, constants and helpers of the mfm track sector extractor
// ----------------------------------------------------------------------------
package mfm_pkg;

	localparam int MAX_SECTORS   = 64;
	localparam int MAX_SIZE_CODE = 7;

	localparam int BYTE_W      = 8;
	localparam int INDEX_W     = 14;
	localparam int ORDINAL_W   = 6;
	localparam int COUNT_W     = 7;
	localparam int SIZE_W      = 3;
	localparam int SECT_LEN_W  = 15;
	localparam int FILL_W      = 4;
	localparam int WINDOW_W    = 64;

	localparam logic [WINDOW_W-1:0] ID_MARK   = 64'h0000_0000_A1A1_A1FE;
	localparam logic [31:0]         DATA_MARK = 32'hA1A1_A1FB;
	localparam int                  BASE_SECTOR_LEN = 128;

	localparam logic [FILL_W-1:0] FILL_FULL = 4'd8;
	localparam logic [FILL_W-1:0] FILL_DATA = 4'd4;

	typedef enum logic [2:0] {
		PH_HUNT_ID,
		PH_TAKE_ID,
		PH_HUNT_DATA,
		PH_DATA,
		PH_ENDED
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ID,
		KIND_DATA,
		KIND_SUMMARY
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [BYTE_W-1:0]     cylinder;
		logic [BYTE_W-1:0]     head_id;
		logic [BYTE_W-1:0]     sector_id;
		logic [BYTE_W-1:0]     size_code;
		logic                  size_clamped;
		logic [BYTE_W-1:0]     data_byte;
		logic [INDEX_W-1:0]    byte_index;
		logic [ORDINAL_W-1:0]  sector_number;
		logic [COUNT_W-1:0]    sector_count;
		logic                  last;
	} result_t;

	// size code clamped to the largest supported sector
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [BYTE_W-1:0] code);
		if (code > BYTE_W'(MAX_SIZE_CODE)) begin
			return SIZE_W'(MAX_SIZE_CODE);
		end
		return code[SIZE_W-1:0];
	endfunction

	function automatic logic size_over(input logic [BYTE_W-1:0] code);
		return code > BYTE_W'(MAX_SIZE_CODE);
	endfunction

	// sector length in bytes, 128 shifted by the clamped code
	function automatic logic [SECT_LEN_W-1:0] sector_len(input logic [SIZE_W-1:0] n);
		return SECT_LEN_W'(BASE_SECTOR_LEN) << n;
	endfunction

endpackage

@@ src/mfm_in_if.sv @@
// ----------------------------------------------------------------------------
// mfm_in_if
// track byte channel: valid/ready handshake with the byte and its end flag
// ----------------------------------------------------------------------------
interface mfm_in_if;
	logic                       valid;
	logic                       ready;
	logic [mfm_pkg::BYTE_W-1:0] track_byte;
	logic                       track_end;

	modport source (output valid, output track_byte, output track_end, input ready);
	modport sink   (input valid, input track_byte, input track_end, output ready);
endinterface

@@ src/mfm_out_if.sv @@
// ----------------------------------------------------------------------------
// mfm_out_if
// result channel: sector id records, data bytes and track summaries
// ----------------------------------------------------------------------------
interface mfm_out_if;
	logic                          valid;
	logic                          ready;
	mfm_pkg::kind_t                kind;
	logic [mfm_pkg::BYTE_W-1:0]    cylinder;
	logic [mfm_pkg::BYTE_W-1:0]    head_id;
	logic [mfm_pkg::BYTE_W-1:0]    sector_id;
	logic [mfm_pkg::BYTE_W-1:0]    size_code;
	logic                          size_clamped;
	logic [mfm_pkg::BYTE_W-1:0]    data_byte;
	logic [mfm_pkg::INDEX_W-1:0]   byte_index;
	logic [mfm_pkg::ORDINAL_W-1:0] sector_number;
	logic [mfm_pkg::COUNT_W-1:0]   sector_count;
	logic                          last;

	modport source (output valid, output kind, output cylinder, output head_id,
		output sector_id, output size_code, output size_clamped, output data_byte,
		output byte_index, output sector_number, output sector_count, output last,
		input ready);
	modport sink (input valid, input kind, input cylinder, input head_id,
		input sector_id, input size_code, input size_clamped, input data_byte,
		input byte_index, input sector_number, input sector_count, input last,
		output ready);
endinterface

@@ src/mfm_track_sector_extractor_unit.sv @@
// result words are registered in the result queue and offered from its head
// one track byte per cycle while the result queue has two free slots; a track-end
//   byte that also closes a data byte or an id record yields two words and drops ready
// the limit is the three-word result queue, which takes a byte only with two free slots
// reset (arst_n low, asynchronous): hunting an id mark, all counters and queue empty
// ----------------------------------------------------------------------------
// mfm_track_sector_extractor_unit
// parses decoded mfm track bytes into sector id records, data bytes and a summary
// ----------------------------------------------------------------------------
module mfm_track_sector_extractor_unit (
	input  logic        clk,
	input  logic        arst_n,
	mfm_in_if.sink      in_ch,
	mfm_out_if.source   out_ch
);

	localparam int QDEPTH = 3;

	// parser state
	mfm_pkg::phase_t                      phase_q, phase_n;
	logic [mfm_pkg::WINDOW_W-1:0]         win_q, win_n;
	logic [mfm_pkg::FILL_W-1:0]           fill_q, fill_n;
	logic [1:0]                           taken_q, taken_n;
	logic [31:0]                          id_q, id_n;
	logic [mfm_pkg::SECT_LEN_W-1:0]       left_q, left_n;
	logic [mfm_pkg::COUNT_W-1:0]          found_q, found_n;

	// result queue, entry 0 faces the output
	mfm_pkg::result_t                     queue_q [QDEPTH];
	mfm_pkg::result_t                     queue_n [QDEPTH];
	logic [1:0]                           cnt_q, cnt_n;

	logic                                 accept;
	logic                                 pop;
	logic [1:0]                           n_res;
	mfm_pkg::result_t                     res0, res1;

	// combinational helpers
	logic [mfm_pkg::WINDOW_W-1:0]         win_shift;
	logic [mfm_pkg::FILL_W-1:0]           fill_inc;
	logic [31:0]                          id_full;
	logic [mfm_pkg::SIZE_W-1:0]           size_cur;
	logic [mfm_pkg::SECT_LEN_W-1:0]       len_cur;
	logic [mfm_pkg::SECT_LEN_W-1:0]       pos_cur;
	logic [1:0]                           cnt_pop;
	mfm_pkg::result_t                     rec;

	assign accept = in_ch.valid && in_ch.ready;
	assign pop    = out_ch.valid && out_ch.ready;

	// take a byte only while two slots are free, so a track end fits its summary
	assign in_ch.ready = (cnt_q <= 2'd1);

	// next parser state and the words one byte produces
	always_comb begin
		phase_n = phase_q;
		win_n   = win_q;
		fill_n  = fill_q;
		taken_n = taken_q;
		id_n    = id_q;
		left_n  = left_q;
		found_n = found_q;
		res0    = '0;
		res1    = '0;
		n_res   = 2'd0;
		rec     = '0;

		win_shift = {win_q[mfm_pkg::WINDOW_W-9:0], in_ch.track_byte};
		fill_inc  = (fill_q < mfm_pkg::FILL_FULL) ? fill_q + 4'd1 : fill_q;
		id_full   = {in_ch.track_byte, id_q[23:0]};
		size_cur  = mfm_pkg::clamp_size(id_q[31:24]);
		len_cur   = mfm_pkg::sector_len(size_cur);
		pos_cur   = len_cur - left_q;

		// id fields carried by records and data bytes
		rec.cylinder     = id_q[7:0];
		rec.head_id      = id_q[15:8];
		rec.sector_id    = id_q[23:16];
		rec.size_code    = mfm_pkg::BYTE_W'(size_cur);
		rec.size_clamped = mfm_pkg::size_over(id_q[31:24]);

		case (phase_q)
			mfm_pkg::PH_HUNT_ID: begin
				win_n  = win_shift;
				fill_n = fill_inc;
				if (fill_inc == mfm_pkg::FILL_FULL && win_shift == mfm_pkg::ID_MARK) begin
					phase_n = mfm_pkg::PH_TAKE_ID;
					fill_n  = '0;
					win_n   = '0;
					taken_n = '0;
					id_n    = '0;
				end
			end
			mfm_pkg::PH_TAKE_ID: begin
				id_n[8*taken_q +: 8] = in_ch.track_byte;
				if (taken_q != 2'd3) begin
					taken_n = taken_q + 2'd1;
				end else begin
					taken_n = '0;
					fill_n  = '0;
					win_n   = '0;
					if (id_full == '0) begin
						// all-zero id ends the listing for this track
						phase_n = mfm_pkg::PH_ENDED;
					end else begin
						res0              = '0;
						res0.kind         = mfm_pkg::KIND_ID;
						res0.cylinder     = id_full[7:0];
						res0.head_id      = id_full[15:8];
						res0.sector_id    = id_full[23:16];
						res0.size_code    = mfm_pkg::BYTE_W'(mfm_pkg::clamp_size(id_full[31:24]));
						res0.size_clamped = mfm_pkg::size_over(id_full[31:24]);
						res0.sector_number = (found_q < mfm_pkg::COUNT_W'(mfm_pkg::MAX_SECTORS))
							? found_q[mfm_pkg::ORDINAL_W-1:0]
							: mfm_pkg::ORDINAL_W'(mfm_pkg::MAX_SECTORS - 1);
						n_res = 2'd1;
						if (found_q < mfm_pkg::COUNT_W'(mfm_pkg::MAX_SECTORS)) begin
							found_n = found_q + 7'd1;
						end
						phase_n = mfm_pkg::PH_HUNT_DATA;
					end
				end
			end
			mfm_pkg::PH_HUNT_DATA: begin
				win_n  = win_shift;
				fill_n = fill_inc;
				if (fill_inc >= mfm_pkg::FILL_DATA && win_shift[31:0] == mfm_pkg::DATA_MARK) begin
					phase_n = mfm_pkg::PH_DATA;
					fill_n  = '0;
					win_n   = '0;
					left_n  = len_cur;
				end
			end
			mfm_pkg::PH_DATA: begin
				res0               = rec;
				res0.kind          = mfm_pkg::KIND_DATA;
				res0.data_byte     = in_ch.track_byte;
				res0.byte_index    = pos_cur[mfm_pkg::INDEX_W-1:0];
				res0.sector_number = (found_q != '0)
					? mfm_pkg::ORDINAL_W'(found_q - 7'd1) : '0;
				res0.last          = (left_q <= 15'd1);
				n_res = 2'd1;
				if (left_q <= 15'd1) begin
					left_n  = '0;
					phase_n = mfm_pkg::PH_HUNT_ID;
					fill_n  = '0;
					win_n   = '0;
				end else begin
					left_n = left_q - 15'd1;
				end
			end
			default: begin
				// listing ended: bytes are dropped until the track end
			end
		endcase

		// track end: summary after the byte's own word, then back to reset state
		if (in_ch.track_end) begin
			if (n_res == 2'd0) begin
				res0              = '0;
				res0.kind         = mfm_pkg::KIND_SUMMARY;
				res0.sector_count = found_n;
				res0.last         = 1'b1;
			end else begin
				res1              = '0;
				res1.kind         = mfm_pkg::KIND_SUMMARY;
				res1.sector_count = found_n;
				res1.last         = 1'b1;
			end
			n_res   = n_res + 2'd1;
			phase_n = mfm_pkg::PH_HUNT_ID;
			win_n   = '0;
			fill_n  = '0;
			taken_n = '0;
			id_n    = '0;
			left_n  = '0;
			found_n = '0;
		end
	end

	// result queue: shift out at entry 0, new words land right behind the survivors
	always_comb begin
		cnt_pop = cnt_q - {1'b0, pop};
		for (int i = 0; i < QDEPTH; i++) begin
			if (pop && i < QDEPTH - 1) begin
				queue_n[i] = queue_q[i+1];
			end else begin
				queue_n[i] = queue_q[i];
			end
			if (accept && n_res != 2'd0 && 2'(i) == cnt_pop) begin
				queue_n[i] = res0;
			end else if (accept && n_res == 2'd2 && 2'(i) == cnt_pop + 2'd1) begin
				queue_n[i] = res1;
			end
		end
		cnt_n = accept ? cnt_pop + n_res : cnt_pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mfm_pkg::PH_HUNT_ID;
			win_q   <= '0;
			fill_q  <= '0;
			taken_q <= '0;
			id_q    <= '0;
			left_q  <= '0;
			found_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				win_q   <= win_n;
				fill_q  <= fill_n;
				taken_q <= taken_n;
				id_q    <= id_n;
				left_q  <= left_n;
				found_q <= found_n;
			end
			cnt_q <= cnt_n;
		end
	end

	// queue payload needs no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			queue_q[i] <= queue_n[i];
		end
	end

	// output word is the head of the queue
	assign out_ch.valid         = (cnt_q != '0);
	assign out_ch.kind          = queue_q[0].kind;
	assign out_ch.cylinder      = queue_q[0].cylinder;
	assign out_ch.head_id       = queue_q[0].head_id;
	assign out_ch.sector_id     = queue_q[0].sector_id;
	assign out_ch.size_code     = queue_q[0].size_code;
	assign out_ch.size_clamped  = queue_q[0].size_clamped;
	assign out_ch.data_byte     = queue_q[0].data_byte;
	assign out_ch.byte_index    = queue_q[0].byte_index;
	assign out_ch.sector_number = queue_q[0].sector_number;
	assign out_ch.sector_count  = queue_q[0].sector_count;
	assign out_ch.last          = queue_q[0].last;

	// the queue never overflows its three slots
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3 || !in_ch.ready)
		else $error("byte taken with a full result queue");

	// a track-end byte always leaves a word waiting
	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.track_end) |=> out_ch.valid)
		else $error("track end produced no summary");

	// outstanding data only while sector data is flowing
	a_left_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != mfm_pkg::PH_DATA |-> left_q == '0)
		else $error("data count left over outside the data phase");

	// a data byte is never accepted with a zero count
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mfm_pkg::PH_DATA |-> left_q != '0)
		else $error("data phase with nothing left to emit");

	// sector tally stays within its bound
	a_found_cap: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= mfm_pkg::COUNT_W'(mfm_pkg::MAX_SECTORS))
		else $error("sector tally past its limit");

endmodule

@@ tb/tb_mfm_track_sector_extractor_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mfm_track_sector_extractor_unit
// self-checking bench: tracks of id marks, id fields, data marks and sector
// data go in with random gaps; every result word is checked against a
// cycle-free model of the sector parser with random output stalls
// ----------------------------------------------------------------------------
module tb_mfm_track_sector_extractor_unit;

	// one track byte as the driver sees it
	typedef struct {
		logic [mfm_pkg::BYTE_W-1:0] tbyte;
		logic                       tend;
		int unsigned                gap;  // idle cycles before the word goes on the bus
		bit                         hold; // wait for every expected word first
	} track_item_t;

	logic clk;
	logic arst_n;

	mfm_in_if  in_if ();
	mfm_out_if out_if ();

	mfm_track_sector_extractor_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	track_item_t      track_stream[$];   // bytes still to be driven
	mfm_pkg::result_t expected_words[$]; // words the parser must still produce

	int unsigned fails;
	int unsigned bytes_sent;
	int unsigned id_seen;
	int unsigned data_seen;
	int unsigned summary_seen;

	// ------------------------------------------------------------------
	// parser model state
	// ------------------------------------------------------------------
	logic [mfm_pkg::WINDOW_W-1:0]   win;       // bytes of the current phase, newest low
	mfm_pkg::phase_t                ph;
	logic [mfm_pkg::FILL_W-1:0]     fill;      // bytes seen in this phase, saturating
	logic [1:0]                     id_taken;
	logic [31:0]                    idf;       // cylinder low .. size code high
	logic [mfm_pkg::SECT_LEN_W-1:0] left;      // data bytes still to come
	logic [mfm_pkg::COUNT_W-1:0]    found;     // sectors listed so far

	function automatic void model_reset();
		win      = '0;
		ph       = mfm_pkg::PH_HUNT_ID;
		fill     = '0;
		id_taken = '0;
		idf      = '0;
		left     = '0;
		found    = '0;
	endfunction

	// every phase change clears the match window, so marks never straddle phases
	function automatic void next_phase(mfm_pkg::phase_t p);
		ph   = p;
		fill = '0;
		win  = '0;
	endfunction

	// sector length from the captured size code, clamped to the largest size
	function automatic logic [mfm_pkg::SECT_LEN_W-1:0] sector_bytes();
		logic [mfm_pkg::BYTE_W-1:0] n;
		n = idf[31:24];
		if (n > mfm_pkg::BYTE_W'(mfm_pkg::MAX_SIZE_CODE)) begin
			n = mfm_pkg::BYTE_W'(mfm_pkg::MAX_SIZE_CODE);
		end
		return mfm_pkg::SECT_LEN_W'(mfm_pkg::BASE_SECTOR_LEN) << n[mfm_pkg::SIZE_W-1:0];
	endfunction

	// id part shared by id records and data bytes
	function automatic mfm_pkg::result_t id_fields(mfm_pkg::kind_t k,
		logic [mfm_pkg::ORDINAL_W-1:0] ord);
		mfm_pkg::result_t           r;
		logic [mfm_pkg::BYTE_W-1:0] n;
		r               = '0;
		n               = idf[31:24];
		r.kind          = k;
		r.cylinder      = idf[7:0];
		r.head_id       = idf[15:8];
		r.sector_id     = idf[23:16];
		r.size_clamped  = n > mfm_pkg::BYTE_W'(mfm_pkg::MAX_SIZE_CODE);
		r.size_code     = r.size_clamped ? mfm_pkg::BYTE_W'(mfm_pkg::MAX_SIZE_CODE) : n;
		r.sector_number = ord;
		return r;
	endfunction

	// advance the model by one accepted track byte, queue the words it causes
	task automatic parse_track_byte(input logic [mfm_pkg::BYTE_W-1:0] b, input logic e);
		mfm_pkg::result_t               r;
		logic [mfm_pkg::SECT_LEN_W-1:0] total;
		logic [mfm_pkg::ORDINAL_W-1:0]  ord;
		case (ph)
			mfm_pkg::PH_HUNT_ID: begin
				win = {win[mfm_pkg::WINDOW_W-9:0], b};
				if (fill < mfm_pkg::FILL_FULL) fill++;
				if (fill >= mfm_pkg::FILL_FULL && win == mfm_pkg::ID_MARK) begin
					next_phase(mfm_pkg::PH_TAKE_ID);
					id_taken = '0;
					idf      = '0;
				end
			end
			mfm_pkg::PH_TAKE_ID: begin
				idf = idf | (32'(b) << (8 * id_taken));
				if (id_taken < 2'd3) begin
					id_taken++;
				end else begin
					id_taken = '0;
					if (idf == '0) begin
						// all-zero id closes the listing for the rest of the track
						next_phase(mfm_pkg::PH_ENDED);
					end else begin
						ord = (found < mfm_pkg::MAX_SECTORS)
							? mfm_pkg::ORDINAL_W'(found)
							: mfm_pkg::ORDINAL_W'(mfm_pkg::MAX_SECTORS - 1);
						expected_words.push_back(id_fields(mfm_pkg::KIND_ID, ord));
						if (found < mfm_pkg::MAX_SECTORS) found++;
						next_phase(mfm_pkg::PH_HUNT_DATA);
					end
				end
			end
			mfm_pkg::PH_HUNT_DATA: begin
				win = {win[mfm_pkg::WINDOW_W-9:0], b};
				if (fill < mfm_pkg::FILL_FULL) fill++;
				if (fill >= mfm_pkg::FILL_DATA && win[31:0] == mfm_pkg::DATA_MARK) begin
					next_phase(mfm_pkg::PH_DATA);
					left = sector_bytes();
				end
			end
			mfm_pkg::PH_DATA: begin
				total = sector_bytes();
				ord   = (found > '0) ? mfm_pkg::ORDINAL_W'(found - 7'd1) : '0;
				r             = id_fields(mfm_pkg::KIND_DATA, ord);
				r.data_byte   = b;
				r.byte_index  = mfm_pkg::INDEX_W'(total - left);
				r.last        = (left <= 1);
				expected_words.push_back(r);
				if (left <= 1) begin
					left = '0;
					next_phase(mfm_pkg::PH_HUNT_ID);
				end else begin
					left--;
				end
			end
			default: ;
		endcase
		if (e) begin
			// track end: summary after the byte itself, then back to reset state
			r              = '0;
			r.kind         = mfm_pkg::KIND_SUMMARY;
			r.sector_count = found;
			r.last         = 1'b1;
			expected_words.push_back(r);
			model_reset();
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	bit tx_calm;

	task automatic put_byte(input logic [mfm_pkg::BYTE_W-1:0] b);
		track_item_t it;
		it.tbyte = b;
		it.tend  = 1'b0;
		it.hold  = 1'b0;
		it.gap   = tx_calm ? 0 : $urandom_range(0, 3);
		// switch between gappy and back-to-back stretches now and then
		if ($urandom_range(0, 63) == 0) tx_calm = ~tx_calm;
		track_stream.push_back(it);
	endtask

	task automatic close_track();
		track_stream[track_stream.size()-1].tend = 1'b1;
	endtask

	task automatic put_gap(input int n);
		logic [mfm_pkg::BYTE_W-1:0] b;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0:       b = 8'h4E;
				1:       b = 8'h00;
				2:       b = 8'hA1;
				default: b = mfm_pkg::BYTE_W'($urandom);
			endcase
			put_byte(b);
		end
	endtask

	task automatic put_id_mark(input bit broken);
		logic [mfm_pkg::WINDOW_W-1:0] m;
		int                           k;
		m = mfm_pkg::ID_MARK;
		if (broken) begin
			k = $urandom_range(0, 7);
			m[8*k +: 8] = mfm_pkg::BYTE_W'($urandom);
		end
		for (int i = 7; i >= 0; i--) put_byte(m[8*i +: 8]);
	endtask

	task automatic put_data_mark(input bit broken);
		logic [31:0] m;
		int          k;
		m = mfm_pkg::DATA_MARK;
		if (broken) begin
			k = $urandom_range(0, 3);
			m[8*k +: 8] = mfm_pkg::BYTE_W'($urandom);
		end
		for (int i = 3; i >= 0; i--) put_byte(m[8*i +: 8]);
	endtask

	task automatic put_sector(input logic [mfm_pkg::BYTE_W-1:0] sz, input int data_cnt,
		input bit broken);
		logic [mfm_pkg::BYTE_W-1:0] c;
		logic [mfm_pkg::BYTE_W-1:0] h;
		logic [mfm_pkg::BYTE_W-1:0] s;
		c = mfm_pkg::BYTE_W'($urandom);
		h = mfm_pkg::BYTE_W'($urandom);
		s = mfm_pkg::BYTE_W'($urandom);
		// a data mark prefix inside the id field must not count
		if ($urandom_range(0, 15) == 0) begin
			c = 8'hA1;
			h = 8'hA1;
			s = 8'hA1;
		end
		put_gap($urandom_range(0, 5));
		put_id_mark(broken && $urandom_range(0, 1) == 1);
		put_byte(c);
		put_byte(h);
		put_byte(s);
		put_byte(sz);
		if ($urandom_range(0, 15) == 0) put_byte(8'hFB);
		put_gap($urandom_range(0, 4));
		put_data_mark(broken && $urandom_range(0, 1) == 1);
		for (int i = 0; i < data_cnt; i++) put_byte(mfm_pkg::BYTE_W'($urandom));
	endtask

	// one track of up to three sectors, ending anywhere
	task automatic put_random_track();
		int                         first;
		int                         nsec;
		int                         pick;
		bit                         cut;
		logic [mfm_pkg::BYTE_W-1:0] sz;
		first = track_stream.size();
		cut   = 1'b0;
		nsec  = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) put_gap($urandom_range(1, 12));
		for (int i = 0; i < nsec && !cut; i++) begin
			pick = $urandom_range(0, 15);
			if (pick < 11) begin
				put_sector(8'd0, 128, $urandom_range(0, 7) == 0);
			end else if (pick < 13) begin
				put_sector(8'd1, 256, $urandom_range(0, 7) == 0);
			end else if (pick < 14) begin
				// all-zero id, whatever follows is ignored
				put_id_mark(1'b0);
				for (int j = 0; j < 4; j++) put_byte(8'h00);
				put_gap($urandom_range(0, 3));
				put_data_mark(1'b0);
				put_gap($urandom_range(1, 6));
			end else begin
				// big or oversized code: stop the track inside the sector
				sz = mfm_pkg::BYTE_W'($urandom_range(2, 255));
				put_sector(sz, $urandom_range(1, 40), 1'b0);
				cut = 1'b1;
			end
		end
		if (!cut) begin
			case ($urandom_range(0, 2))
				0: put_gap($urandom_range(1, 6));
				1: ;
				default: begin
					pick = $urandom_range(0, track_stream.size() - first);
					for (int j = 0; j < pick && track_stream.size() > first + 1; j++) begin
						void'(track_stream.pop_back());
					end
				end
			endcase
		end
		if (track_stream.size() == first) put_byte(mfm_pkg::BYTE_W'($urandom));
		close_track();
		if ($urandom_range(0, 3) == 0) track_stream[first].hold = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// driver: one track byte per word, random gap before each
	// ------------------------------------------------------------------
	int unsigned gap_cnt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid      <= 1'b0;
			in_if.track_byte <= '0;
			in_if.track_end  <= 1'b0;
			gap_cnt          <= 0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				parse_track_byte(in_if.track_byte, in_if.track_end);
				bytes_sent++;
			end
			// bus free: either nothing offered or the word just went in
			if (!in_if.valid || in_if.ready) begin
				if (track_stream.size() == 0) begin
					in_if.valid <= 1'b0;
				end else if (gap_cnt < track_stream[0].gap) begin
					in_if.valid <= 1'b0;
					gap_cnt     <= gap_cnt + 1;
				end else if (track_stream[0].hold && expected_words.size() != 0) begin
					// drain the parser completely before this word
					in_if.valid <= 1'b0;
				end else begin
					in_if.valid      <= 1'b1;
					in_if.track_byte <= track_stream[0].tbyte;
					in_if.track_end  <= track_stream[0].tend;
					void'(track_stream.pop_front());
					gap_cnt          <= 0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: random stalls on ready, each word checked in order
	// ------------------------------------------------------------------
	int unsigned stall_cnt;
	int unsigned stall_draw;
	bit          rx_calm;

	task automatic cmp_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic check_word(input mfm_pkg::result_t got);
		mfm_pkg::result_t want;
		if (expected_words.size() == 0) begin
			$error("kind: expected no word, got %0d", got.kind);
			fails++;
			return;
		end
		want = expected_words.pop_front();
		cmp_field("kind", want.kind, got.kind);
		cmp_field("cylinder", want.cylinder, got.cylinder);
		cmp_field("head_id", want.head_id, got.head_id);
		cmp_field("sector_id", want.sector_id, got.sector_id);
		cmp_field("size_code", want.size_code, got.size_code);
		cmp_field("size_clamped", want.size_clamped, got.size_clamped);
		cmp_field("data_byte", want.data_byte, got.data_byte);
		cmp_field("byte_index", want.byte_index, got.byte_index);
		cmp_field("sector_number", want.sector_number, got.sector_number);
		cmp_field("sector_count", want.sector_count, got.sector_count);
		cmp_field("last", want.last, got.last);
		case (got.kind)
			mfm_pkg::KIND_ID:   id_seen++;
			mfm_pkg::KIND_DATA: data_seen++;
			default:            summary_seen++;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_cnt    <= 0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				check_word('{kind: out_if.kind, cylinder: out_if.cylinder,
					head_id: out_if.head_id, sector_id: out_if.sector_id,
					size_code: out_if.size_code, size_clamped: out_if.size_clamped,
					data_byte: out_if.data_byte, byte_index: out_if.byte_index,
					sector_number: out_if.sector_number,
					sector_count: out_if.sector_count, last: out_if.last});
				if ($urandom_range(0, 63) == 0) rx_calm = ~rx_calm;
				stall_draw = rx_calm ? 0 : $urandom_range(0, 3);
				if (stall_draw > 0) begin
					out_if.ready <= 1'b0;
					stall_cnt    <= stall_draw - 1;
				end else begin
					out_if.ready <= 1'b1;
				end
			end else if (stall_cnt > 0) begin
				out_if.ready <= 1'b0;
				stall_cnt    <= stall_cnt - 1;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int base;
		arst_n           = 1'b0;
		in_if.valid      = 1'b0;
		in_if.track_byte = '0;
		in_if.track_end  = 1'b0;
		out_if.ready     = 1'b0;
		fails            = 0;
		bytes_sent       = 0;
		id_seen          = 0;
		data_seen        = 0;
		summary_seen     = 0;
		tx_calm          = 1'b0;
		rx_calm          = 1'b0;
		model_reset();

		// directed: lone end bytes at both byte extremes
		put_byte(8'h00);
		close_track();
		put_byte(8'hFF);
		close_track();
		// oversized code, id record and summary from the same byte
		put_id_mark(1'b0);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'hFF);
		close_track();
		// all-zero id: the data mark after it is ignored
		put_id_mark(1'b0);
		for (int i = 0; i < 4; i++) put_byte(8'h00);
		put_data_mark(1'b0);
		put_byte(8'h55);
		close_track();

		// random tracks, the first one waits for a fully drained parser
		base = track_stream.size();
		put_random_track();
		track_stream[base].hold = 1'b1;
		while (track_stream.size() < 1050) begin
			put_random_track();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (track_stream.size() != 0 || in_if.valid || expected_words.size() != 0) begin
			@(posedge clk);
		end
		// wait on to catch stray words
		repeat (8) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("words left over: expected 0, got %0d", expected_words.size());
			fails++;
		end

		$display("sent %0d track bytes over %0d tracks with random gaps and stalls",
			bytes_sent, summary_seen);
		$display("checked %0d id records and %0d data bytes, %0d mismatches",
			id_seen, data_seen, fails);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
